FILE: src/srsi_pkg.sv
// ----------------------------------------------------------------------------
// srsi_pkg: shared types and constants for the stochastic rsi oscillator
// widths of the sample and divider datapath, register codes, fsm states
// ----------------------------------------------------------------------------
package srsi_pkg;

	localparam int RSI_W   = 14;
	localparam int NUM_W   = 27;
	localparam int CFG_K_W = 5;
	localparam int CFG_D_W = 4;
	localparam int DIV_CW  = 4;
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;

	localparam logic [RSI_W-1:0]   RSI_FULL_SCALE = 14'd10000;
	localparam logic [RSI_W-1:0]   RSI_MIN_INIT   = 14'h3fff;
	localparam logic [CFG_K_W-1:0] K_PERIOD_RESET = 5'd14;
	localparam logic [CFG_D_W-1:0] D_PERIOD_RESET = 4'd3;

	typedef enum logic [0:0] {
		REG_K_PERIOD = 1'b0,
		REG_D_PERIOD = 1'b1
	} reg_idx_t;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_SCAN = 7'b0000010,
		ST_KDIV = 7'b0000100,
		ST_PUSH = 7'b0001000,
		ST_SUM  = 7'b0010000,
		ST_DDIV = 7'b0100000,
		ST_DONE = 7'b1000000
	} srsi_state_t;

	typedef struct packed {
		logic              start;
		logic [NUM_W-1:0]  num;
		logic [RSI_W-1:0]  den;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

FILE: src/srsi_mm_cell.sv
// ----------------------------------------------------------------------------
// srsi_mm_cell: one tap of the rsi history with a running min/max stage
// holds one sample and folds it into the min/max handed down the row
// ----------------------------------------------------------------------------
module srsi_mm_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      shift_en,
	input  logic                      in_window,
	input  logic [srsi_pkg::RSI_W-1:0] sample_in,
	input  logic [srsi_pkg::RSI_W-1:0] lo_in,
	input  logic [srsi_pkg::RSI_W-1:0] hi_in,
	output logic [srsi_pkg::RSI_W-1:0] sample_out,
	output logic [srsi_pkg::RSI_W-1:0] lo_out,
	output logic [srsi_pkg::RSI_W-1:0] hi_out
);

	logic [srsi_pkg::RSI_W-1:0] sample_q;
	logic [srsi_pkg::RSI_W-1:0] lo_q;
	logic [srsi_pkg::RSI_W-1:0] hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
		end else if (shift_en) begin
			sample_q <= sample_in;
		end
	end

	// cells outside the window just pass the running values along
	always_ff @(posedge clk) begin
		if (in_window && (sample_q < lo_in)) begin
			lo_q <= sample_q;
		end else begin
			lo_q <= lo_in;
		end
		if (in_window && (sample_q > hi_in)) begin
			hi_q <= sample_q;
		end else begin
			hi_q <= hi_in;
		end
	end

	assign sample_out = sample_q;
	assign lo_out     = lo_q;
	assign hi_out     = hi_q;

endmodule

FILE: src/srsi_sum_cell.sv
// ----------------------------------------------------------------------------
// srsi_sum_cell: one tap of the %K history with a running sum stage
// holds one %K value and adds it to the partial sum handed down the row
// ----------------------------------------------------------------------------
module srsi_sum_cell #(
	parameter int SUM_W = 18
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      shift_en,
	input  logic                      in_window,
	input  logic [srsi_pkg::RSI_W-1:0] k_in,
	input  logic [SUM_W-1:0]          sum_in,
	output logic [srsi_pkg::RSI_W-1:0] k_out,
	output logic [SUM_W-1:0]          sum_out
);

	logic [srsi_pkg::RSI_W-1:0] k_q;
	logic [SUM_W-1:0]          sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (shift_en) begin
			k_q <= k_in;
		end
	end

	always_ff @(posedge clk) begin
		if (in_window) begin
			sum_q <= sum_in + SUM_W'(k_q);
		end else begin
			sum_q <= sum_in;
		end
	end

	assign k_out   = k_q;
	assign sum_out = sum_q;

endmodule

FILE: src/srsi_div.sv
// ----------------------------------------------------------------------------
// srsi_div: restoring divider, one quotient bit per cycle
// quotient must fit in RSI_W bits, i.e. num < den << RSI_W
// ----------------------------------------------------------------------------
module srsi_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  srsi_pkg::div_req_t         req,
	output srsi_pkg::div_stat_t        stat,
	output logic [srsi_pkg::RSI_W-1:0] quo
);

	logic [srsi_pkg::DIV_CW-1:0] cnt_q;
	logic                        done_q;
	logic [srsi_pkg::NUM_W-1:0]  rem_q;
	logic [srsi_pkg::NUM_W-1:0]  dsh_q;
	logic [srsi_pkg::RSI_W-1:0]  quo_q;
	logic                        ge;

	assign ge = (rem_q >= dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (req.start) begin
			cnt_q  <= srsi_pkg::DIV_CW'(srsi_pkg::RSI_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - srsi_pkg::DIV_CW'(1);
			done_q <= (cnt_q == srsi_pkg::DIV_CW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num;
			dsh_q <= srsi_pkg::NUM_W'(req.den) << (srsi_pkg::RSI_W - 1);
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[srsi_pkg::RSI_W-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;
	assign quo       = quo_q;

endmodule

FILE: src/stochastic_rsi_oscillator_unit.sv
// ----------------------------------------------------------------------------
// stochastic_rsi_oscillator_unit: streaming stochastic rsi (%K and %D)
// a row of min/max cells over the rsi history, a row of sum cells over the
// %K history, and one shared bit-serial divider
// ----------------------------------------------------------------------------
//
//  channel   signals                             direction  content
//  -------   ---------------------------------   ---------  ---------------------
//  in        in_valid/in_ready, rsi_value        sink       one rsi request
//  out       out_valid/out_ready, k_value,       source     one result request
//            k_valid, d_value, d_valid,
//            flat_window
//  cfg       psel/penable/pwrite/paddr/pwdata,   slave      k_period at 0x0,
//            prdata, pready                                 d_period at 0x4
//
//  sequence: one request at a time; the request is accepted, the min/max row
//  settles, the %K divide runs, the %K value is pushed, the sum row settles,
//  the %D divide runs and the output register is loaded; the pace is set by
//  the two cell rows and the one-bit-per-cycle divider; a flat window or too
//  few %K values skips a divide, too few samples ends after the scan
//  reset: arst_n clears histories, sample count, fsm and output valid
//  stalls: the finished result waits in the output register; the next request
//  is taken meanwhile and only holds in its last state if out is still full
// ----------------------------------------------------------------------------
module stochastic_rsi_oscillator_unit #(
	parameter int MAX_K_WINDOW = 16,
	parameter int MAX_D_WINDOW = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// rsi input
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [srsi_pkg::RSI_W-1:0]   rsi_value,
	// result output
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [srsi_pkg::RSI_W-1:0]   k_value,
	output logic                         k_valid,
	output logic [srsi_pkg::RSI_W-1:0]   d_value,
	output logic                         d_valid,
	output logic                         flat_window,
	// configuration
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [srsi_pkg::APB_AW-1:0]  paddr,
	input  logic [srsi_pkg::APB_DW-1:0]  pwdata,
	output logic [srsi_pkg::APB_DW-1:0]  prdata,
	output logic                         pready
);

	// counter wide enough for the saturated sample count and both scans
	localparam int CW    = $clog2(MAX_K_WINDOW + MAX_D_WINDOW + 1);
	localparam int TW    = CW + 1;
	// sum of up to MAX_D_WINDOW values of at most full scale
	localparam int SUM_W = srsi_pkg::RSI_W + $clog2(MAX_D_WINDOW) + 1;

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [srsi_pkg::CFG_K_W-1:0] cfg_k_q;
	logic [srsi_pkg::CFG_D_W-1:0] cfg_d_q;
	logic                         cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	// only the register bit of the address is decoded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_k_q <= srsi_pkg::K_PERIOD_RESET;
			cfg_d_q <= srsi_pkg::D_PERIOD_RESET;
		end else if (cfg_wr) begin
			unique case (srsi_pkg::reg_idx_t'(paddr[2]))
				srsi_pkg::REG_K_PERIOD: cfg_k_q <= pwdata[srsi_pkg::CFG_K_W-1:0];
				srsi_pkg::REG_D_PERIOD: cfg_d_q <= pwdata[srsi_pkg::CFG_D_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (srsi_pkg::reg_idx_t'(paddr[2]))
			srsi_pkg::REG_K_PERIOD: prdata = srsi_pkg::APB_DW'(cfg_k_q);
			srsi_pkg::REG_D_PERIOD: prdata = srsi_pkg::APB_DW'(cfg_d_q);
			default:                prdata = '0;
		endcase
	end

	// effective periods: zero acts as one, too large acts as the maximum
	logic [CW-1:0] kp;
	logic [CW-1:0] dp;

	always_comb begin
		priority if (cfg_k_q == '0) begin
			kp = CW'(1);
		end else if (32'(cfg_k_q) > 32'(MAX_K_WINDOW)) begin
			kp = CW'(MAX_K_WINDOW);
		end else begin
			kp = CW'(cfg_k_q);
		end
		priority if (cfg_d_q == '0) begin
			dp = CW'(1);
		end else if (32'(cfg_d_q) > 32'(MAX_D_WINDOW)) begin
			dp = CW'(MAX_D_WINDOW);
		end else begin
			dp = CW'(cfg_d_q);
		end
	end

	// ------------------------------------------------------------------
	// control state
	// ------------------------------------------------------------------
	srsi_pkg::srsi_state_t       state_q;
	logic [CW-1:0]               cnt_q;
	logic [CW-1:0]               seen_q;
	logic [srsi_pkg::RSI_W-1:0]  cur_q;
	logic [srsi_pkg::RSI_W-1:0]  k_res_q;
	logic                        flat_q;
	logic                        out_valid_q;
	logic [srsi_pkg::RSI_W-1:0]  k_value_q;
	logic                        k_valid_q;
	logic [srsi_pkg::RSI_W-1:0]  d_value_q;
	logic                        d_valid_q;
	logic                        flat_window_q;

	logic                        in_acc;
	logic                        out_acc;
	logic [srsi_pkg::RSI_W-1:0]  sat_sample;
	logic                        scan_end;
	logic                        sum_end;
	logic                        k_ok;
	logic                        d_ok;
	logic                        flat;
	logic                        load_out;
	logic                        push_k;

	// ------------------------------------------------------------------
	// rsi history: row of min/max cells, cell 0 holds the newest sample
	// ------------------------------------------------------------------
	logic [srsi_pkg::RSI_W-1:0] samp_c [MAX_K_WINDOW];
	logic [srsi_pkg::RSI_W-1:0] lo_c   [MAX_K_WINDOW];
	logic [srsi_pkg::RSI_W-1:0] hi_c   [MAX_K_WINDOW];
	logic [MAX_K_WINDOW-1:0]    win_k;

	for (genvar i = 0; i < MAX_K_WINDOW; i++) begin : g_kcell
		assign win_k[i] = (CW'(i) < kp);
		if (i == 0) begin : g_head
			srsi_mm_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.shift_en   (in_acc),
				.in_window  (win_k[i]),
				.sample_in  (sat_sample),
				.lo_in      (srsi_pkg::RSI_MIN_INIT),
				.hi_in      ('0),
				.sample_out (samp_c[i]),
				.lo_out     (lo_c[i]),
				.hi_out     (hi_c[i])
			);
		end else begin : g_body
			srsi_mm_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.shift_en   (in_acc),
				.in_window  (win_k[i]),
				.sample_in  (samp_c[i-1]),
				.lo_in      (lo_c[i-1]),
				.hi_in      (hi_c[i-1]),
				.sample_out (samp_c[i]),
				.lo_out     (lo_c[i]),
				.hi_out     (hi_c[i])
			);
		end
	end

	// ------------------------------------------------------------------
	// %K history: row of sum cells, only valid %K values are pushed
	// ------------------------------------------------------------------
	logic [srsi_pkg::RSI_W-1:0] kh_c  [MAX_D_WINDOW];
	logic [SUM_W-1:0]           sum_c [MAX_D_WINDOW];
	logic [MAX_D_WINDOW-1:0]    win_d;

	for (genvar i = 0; i < MAX_D_WINDOW; i++) begin : g_dcell
		assign win_d[i] = (CW'(i) < dp);
		if (i == 0) begin : g_head
			srsi_sum_cell #(.SUM_W(SUM_W)) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.shift_en  (push_k),
				.in_window (win_d[i]),
				.k_in      (k_res_q),
				.sum_in    ('0),
				.k_out     (kh_c[i]),
				.sum_out   (sum_c[i])
			);
		end else begin : g_body
			srsi_sum_cell #(.SUM_W(SUM_W)) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.shift_en  (push_k),
				.in_window (win_d[i]),
				.k_in      (kh_c[i-1]),
				.sum_in    (sum_c[i-1]),
				.k_out     (kh_c[i]),
				.sum_out   (sum_c[i])
			);
		end
	end

	// ------------------------------------------------------------------
	// shared divider: %K first, then %D
	// ------------------------------------------------------------------
	srsi_pkg::div_req_t          div_req;
	srsi_pkg::div_stat_t         div_stat;
	logic [srsi_pkg::RSI_W-1:0]  div_quo;
	logic [srsi_pkg::RSI_W-1:0]  win_lo;
	logic [srsi_pkg::RSI_W-1:0]  win_hi;

	srsi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.stat   (div_stat),
		.quo    (div_quo)
	);

	assign win_lo = lo_c[MAX_K_WINDOW-1];
	assign win_hi = hi_c[MAX_K_WINDOW-1];

	// ------------------------------------------------------------------
	// handshakes and decisions
	// ------------------------------------------------------------------
	assign in_ready   = (state_q == srsi_pkg::ST_IDLE);
	assign in_acc     = in_valid && in_ready;
	assign out_acc    = out_valid_q && out_ready;
	assign sat_sample = (rsi_value > srsi_pkg::RSI_FULL_SCALE) ?
	                    srsi_pkg::RSI_FULL_SCALE : rsi_value;

	// the row settles one cell per cycle, so wait out its full length
	assign scan_end = (state_q == srsi_pkg::ST_SCAN) && (cnt_q == CW'(MAX_K_WINDOW));
	assign sum_end  = (state_q == srsi_pkg::ST_SUM) && (cnt_q == CW'(MAX_D_WINDOW));
	assign k_ok     = (seen_q >= kp);
	// d_period %K values exist once seen >= kp + dp - 1
	assign d_ok     = ((TW'(seen_q) + TW'(1)) >= (TW'(kp) + TW'(dp)));
	assign flat     = (win_hi == win_lo);
	assign push_k   = (state_q == srsi_pkg::ST_PUSH);
	assign load_out = (state_q == srsi_pkg::ST_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		div_req.start = 1'b0;
		div_req.num   = srsi_pkg::NUM_W'(srsi_pkg::RSI_FULL_SCALE) *
		                srsi_pkg::NUM_W'(cur_q - win_lo);
		div_req.den   = win_hi - win_lo;
		if (scan_end && k_ok && !flat) begin
			div_req.start = 1'b1;
		end else if (sum_end && d_ok) begin
			div_req.start = 1'b1;
			div_req.num   = srsi_pkg::NUM_W'(sum_c[MAX_D_WINDOW-1]);
			div_req.den   = srsi_pkg::RSI_W'(dp);
		end
	end

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srsi_pkg::ST_IDLE;
			cnt_q   <= '0;
			seen_q  <= '0;
		end else begin
			unique case (state_q)
				srsi_pkg::ST_IDLE: begin
					if (in_acc) begin
						cnt_q   <= '0;
						state_q <= srsi_pkg::ST_SCAN;
						if (seen_q != CW'(MAX_K_WINDOW + MAX_D_WINDOW)) begin
							seen_q <= seen_q + CW'(1);
						end
					end
				end
				srsi_pkg::ST_SCAN: begin
					if (!scan_end) begin
						cnt_q <= cnt_q + CW'(1);
					end else if (!k_ok) begin
						state_q <= srsi_pkg::ST_DONE;
					end else if (flat) begin
						state_q <= srsi_pkg::ST_PUSH;
					end else begin
						state_q <= srsi_pkg::ST_KDIV;
					end
				end
				srsi_pkg::ST_KDIV: begin
					if (div_stat.done) begin
						state_q <= srsi_pkg::ST_PUSH;
					end
				end
				srsi_pkg::ST_PUSH: begin
					cnt_q   <= '0;
					state_q <= srsi_pkg::ST_SUM;
				end
				srsi_pkg::ST_SUM: begin
					if (!sum_end) begin
						cnt_q <= cnt_q + CW'(1);
					end else if (d_ok) begin
						state_q <= srsi_pkg::ST_DDIV;
					end else begin
						state_q <= srsi_pkg::ST_DONE;
					end
				end
				srsi_pkg::ST_DDIV: begin
					if (div_stat.done) begin
						state_q <= srsi_pkg::ST_DONE;
					end
				end
				srsi_pkg::ST_DONE: begin
					if (load_out) begin
						state_q <= srsi_pkg::ST_IDLE;
					end
				end
				default: state_q <= srsi_pkg::ST_IDLE;
			endcase
		end
	end

	// working result registers
	logic [srsi_pkg::RSI_W-1:0] d_res_q;
	logic                       k_ok_q;
	logic                       d_ok_q;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cur_q <= sat_sample;
		end
		if (scan_end) begin
			k_ok_q  <= k_ok;
			d_ok_q  <= 1'b0;
			flat_q  <= k_ok && flat;
			k_res_q <= '0;
			d_res_q <= '0;
		end
		if ((state_q == srsi_pkg::ST_KDIV) && div_stat.done) begin
			k_res_q <= div_quo;
		end
		if (sum_end) begin
			d_ok_q <= d_ok;
		end
		if ((state_q == srsi_pkg::ST_DDIV) && div_stat.done) begin
			d_res_q <= div_quo;
		end
	end

	// ------------------------------------------------------------------
	// output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_acc) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			k_value_q     <= k_res_q;
			k_valid_q     <= k_ok_q;
			d_value_q     <= d_res_q;
			d_valid_q     <= d_ok_q;
			flat_window_q <= flat_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign k_value     = k_value_q;
	assign k_valid     = k_valid_q;
	assign d_value     = d_value_q;
	assign d_valid     = d_valid_q;
	assign flat_window = flat_window_q;

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
`ifndef SYNTHESIS
	a_accept_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == srsi_pkg::ST_SCAN)
		else $error("accepted request did not start the window scan");

	a_div_idle_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_stat.busy)
		else $error("divider restarted while busy");

	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == srsi_pkg::ST_KDIV || state_q == srsi_pkg::ST_DDIV))
		else $error("divider finished outside a divide state");

	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (k_value <= srsi_pkg::RSI_FULL_SCALE) &&
		              (d_value <= srsi_pkg::RSI_FULL_SCALE) && (!d_valid || k_valid))
		else $error("result out of range or inconsistent valids");

	a_flat_forces_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && flat_window |-> k_valid && (k_value == '0))
		else $error("flat window without zero k value");
`endif

endmodule
